// File: hdl/ish_pkg.sv
// Shared types, codes and default sizes for the I2C slave transaction handler.
// No dependencies; ish_res_q, ish_ctrl and the top level import this package.
package ish_pkg;

  localparam int RX_DEPTH_DEF = 8;
  localparam int TX_DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    MODE_BUS_EVENT = 2'd0,
    MODE_HOST_WR   = 2'd1,
    MODE_HOST_RD   = 2'd2,
    MODE_ABORT     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE          = 2'd0,
    CMD_RESPOND       = 2'd1,
    CMD_COMPLETE      = 2'd2,
    CMD_NACK_COMPLETE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RES_UNKNOWN  = 3'd0,
    RES_OK       = 3'd1,
    RES_BUSERR   = 3'd2,
    RES_COLL     = 3'd3,
    RES_FAIL     = 3'd4,
    RES_ABORTED  = 3'd5,
    RES_OVERFLOW = 3'd6
  } result_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bus_error;
    logic       collision;
    logic       addr_stop_flag;
    logic       addr_match;
    logic       data_flag;
    logic       master_reads;
    logic       master_nack;
    logic [7:0] rx_byte;
    logic [2:0] host_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] bus_command;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       clear_stop_flag;
    logic       stop_irq_enable;
    logic       busy_res;
    logic [2:0] result_code;
    logic [3:0] rx_count;
    logic [3:0] tx_count;
    logic       rx_strobe;
    logic [7:0] host_data;
  } res_t;

endpackage

// File: hdl/ish_in_if.sv
// Input channel of the transaction handler: valid/ready plus one item word.
// Depends on nothing; field widths follow ish_pkg::in_item_t.
interface ish_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       bus_error;
  logic       collision;
  logic       addr_stop_flag;
  logic       addr_match;
  logic       data_flag;
  logic       master_reads;
  logic       master_nack;
  logic [7:0] rx_byte;
  logic [2:0] host_index;

  modport source (
    output valid, mode, bus_error, collision, addr_stop_flag, addr_match,
           data_flag, master_reads, master_nack, rx_byte, host_index,
    input  ready
  );

  modport sink (
    input  valid, mode, bus_error, collision, addr_stop_flag, addr_match,
           data_flag, master_reads, master_nack, rx_byte, host_index,
    output ready
  );
endinterface

// File: hdl/ish_out_if.sv
// Result channel of the transaction handler: valid/ready plus one result word.
// Depends on nothing; field widths follow ish_pkg::res_t.
interface ish_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_command;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       clear_stop_flag;
  logic       stop_irq_enable;
  logic       busy_res;
  logic [2:0] result_code;
  logic [3:0] rx_count;
  logic [3:0] tx_count;
  logic       rx_strobe;
  logic [7:0] host_data;

  modport source (
    output valid, bus_command, tx_byte, tx_valid, clear_stop_flag,
           stop_irq_enable, busy_res, result_code, rx_count, tx_count,
           rx_strobe, host_data,
    input  ready
  );

  modport sink (
    input  valid, bus_command, tx_byte, tx_valid, clear_stop_flag,
           stop_irq_enable, busy_res, result_code, rx_count, tx_count,
           rx_strobe, host_data,
    output ready
  );
endinterface

// File: hdl/ish_ram.sv
// Simple byte RAM: one write port and one read port with registered read data.
// No dependencies.
module ish_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ish_res_q.sv
// Two-word result queue that decouples the handler from the result channel.
// Depends on ish_pkg for the result word type.
module ish_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ish_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output ish_pkg::res_t out_data
);
  import ish_pkg::*;

  res_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/ish_ctrl.sv
// Item register, transaction state and event decode of the handler.
// Depends on ish_pkg; drives the two byte RAMs and the result queue.
module ish_ctrl #(
  parameter int RX_DEPTH = ish_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ish_pkg::TX_DEPTH_DEF,
  parameter int RX_AW    = 3,
  parameter int TX_AW    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ish_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output ish_pkg::res_t     q_data,
  output logic              rx_we,
  output logic [RX_AW-1:0]  rx_waddr,
  output logic [7:0]        rx_wdata,
  output logic              rx_re,
  output logic [RX_AW-1:0]  rx_raddr,
  input  logic [7:0]        rx_rdata,
  output logic              tx_we,
  output logic [TX_AW-1:0]  tx_waddr,
  output logic [7:0]        tx_wdata,
  output logic              tx_re,
  output logic [TX_AW-1:0]  tx_raddr,
  input  logic [7:0]        tx_rdata
);
  import ish_pkg::*;

  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  // Item register
  logic     s1_vld_r;
  in_item_t s1_r;

  // Transaction state
  logic [RX_CW-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [TX_CW-1:0] tx_cnt_r, tx_cnt_nxt;
  logic             busy_r, busy_nxt;
  result_t          res_r, res_nxt;
  logic             abort_r, abort_nxt;
  logic             stop_en_r, stop_en_nxt;
  logic [TX_DEPTH-1:0] tx_wr_r;

  // Read forwarding, captured alongside the RAM reads
  logic       rx_byp_r, tx_byp_r, tx_ok_r;
  logic [7:0] rx_byp_data_r, tx_byp_data_r;

  logic       advance, in_fire;
  logic       rx_we_c, tx_we_c;
  logic [7:0] rx_rd, tx_rd;
  logic [8:0] s1_idx_ext, in_idx_ext, rxc_ext, txc_ext;
  logic       s1_rx_ok, s1_tx_ok;
  cmd_t       cmd;
  logic [7:0] txb, hdata;
  logic       txv, clr, strobe;

  assign advance  = s1_vld_r && !q_full;
  assign in_ready = !s1_vld_r || !q_full;
  assign in_fire  = in_valid && in_ready;

  assign s1_idx_ext = 9'(s1_r.host_index);
  assign in_idx_ext = 9'(in_item.host_index);
  assign s1_rx_ok   = (s1_idx_ext < 9'(RX_DEPTH));
  assign s1_tx_ok   = (s1_idx_ext < 9'(TX_DEPTH));

  assign rx_rd = rx_byp_r ? rx_byp_data_r : rx_rdata;
  // A send entry that the host never loaded reads as zero.
  assign tx_rd = tx_byp_r ? tx_byp_data_r : (tx_ok_r ? tx_rdata : 8'd0);

  always_comb begin
    rx_cnt_nxt  = rx_cnt_r;
    tx_cnt_nxt  = tx_cnt_r;
    busy_nxt    = busy_r;
    res_nxt     = res_r;
    abort_nxt   = abort_r;
    stop_en_nxt = stop_en_r;
    cmd         = CMD_NONE;
    txb         = 8'd0;
    txv         = 1'b0;
    clr         = 1'b0;
    strobe      = 1'b0;
    hdata       = 8'd0;
    rx_we_c     = 1'b0;
    tx_we_c     = 1'b0;
    if (s1_vld_r) begin
      case (mode_t'(s1_r.mode))
        MODE_HOST_WR: begin
          tx_we_c = s1_tx_ok;
        end
        MODE_HOST_RD: begin
          hdata = s1_rx_ok ? rx_rd : 8'd0;
        end
        MODE_ABORT: begin
          abort_nxt = 1'b1;
        end
        default: begin
          if (s1_r.bus_error || s1_r.collision) begin
            rx_cnt_nxt = '0;
            tx_cnt_nxt = '0;
            busy_nxt   = 1'b0;
            res_nxt    = s1_r.bus_error ? RES_BUSERR : RES_COLL;
          end else if (s1_r.addr_stop_flag && s1_r.addr_match) begin
            if (abort_r) begin
              cmd       = CMD_COMPLETE;
              busy_nxt  = 1'b0;
              res_nxt   = RES_ABORTED;
              abort_nxt = 1'b0;
            end else begin
              busy_nxt    = 1'b1;
              res_nxt     = RES_UNKNOWN;
              stop_en_nxt = 1'b0;
              rx_cnt_nxt  = '0;
              tx_cnt_nxt  = '0;
              cmd         = CMD_RESPOND;
            end
          end else if (s1_r.addr_stop_flag) begin
            stop_en_nxt = 1'b0;
            clr         = 1'b1;
            busy_nxt    = 1'b0;
            res_nxt     = RES_OK;
          end else if (s1_r.data_flag) begin
            if (s1_r.master_reads) begin
              if ((tx_cnt_r != '0) && s1_r.master_nack) begin
                cmd      = CMD_COMPLETE;
                busy_nxt = 1'b0;
                res_nxt  = RES_OK;
              end else if (tx_cnt_r < TX_CW'(TX_DEPTH)) begin
                txb        = tx_rd;
                txv        = 1'b1;
                tx_cnt_nxt = TX_CW'(tx_cnt_r + 1'b1);
                cmd        = CMD_RESPOND;
              end else begin
                cmd      = CMD_COMPLETE;
                busy_nxt = 1'b0;
                res_nxt  = RES_OVERFLOW;
              end
            end else begin
              stop_en_nxt = 1'b1;
              if (rx_cnt_r < RX_CW'(RX_DEPTH)) begin
                rx_we_c    = 1'b1;
                strobe     = 1'b1;
                rx_cnt_nxt = RX_CW'(rx_cnt_r + 1'b1);
                if (abort_r) begin
                  cmd       = CMD_COMPLETE;
                  busy_nxt  = 1'b0;
                  res_nxt   = RES_ABORTED;
                  abort_nxt = 1'b0;
                end else begin
                  cmd = CMD_RESPOND;
                end
              end else begin
                cmd      = CMD_NACK_COMPLETE;
                busy_nxt = 1'b0;
                res_nxt  = RES_OVERFLOW;
              end
            end
          end else begin
            busy_nxt = 1'b0;
            res_nxt  = RES_FAIL;
          end
        end
      endcase
    end
  end

  assign rxc_ext = 9'(rx_cnt_nxt);
  assign txc_ext = 9'(tx_cnt_nxt);

  always_comb begin
    q_push                 = advance;
    q_data.bus_command     = cmd;
    q_data.tx_byte         = txb;
    q_data.tx_valid        = txv;
    q_data.clear_stop_flag = clr;
    q_data.stop_irq_enable = stop_en_nxt;
    q_data.busy_res        = busy_nxt;
    q_data.result_code     = res_nxt;
    q_data.rx_count        = rxc_ext[3:0];
    q_data.tx_count        = txc_ext[3:0];
    q_data.rx_strobe       = strobe;
    q_data.host_data       = hdata;
  end

  // RAM writes happen as the item leaves the register.
  assign rx_we    = advance && rx_we_c;
  assign rx_waddr = rx_cnt_r[RX_AW-1:0];
  assign rx_wdata = s1_r.rx_byte;
  assign tx_we    = advance && tx_we_c;
  assign tx_waddr = s1_idx_ext[TX_AW-1:0];
  assign tx_wdata = s1_r.rx_byte;

  // RAM reads are issued as an item enters, against the state the previous
  // item leaves behind; a write in the same cycle is forwarded.
  assign rx_re    = in_fire;
  assign rx_raddr = (in_idx_ext < 9'(RX_DEPTH)) ? in_idx_ext[RX_AW-1:0] : '0;
  assign tx_re    = in_fire;
  assign tx_raddr = (tx_cnt_nxt < TX_CW'(TX_DEPTH)) ? tx_cnt_nxt[TX_AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      rx_cnt_r  <= '0;
      tx_cnt_r  <= '0;
      busy_r    <= 1'b0;
      res_r     <= RES_UNKNOWN;
      abort_r   <= 1'b0;
      stop_en_r <= 1'b0;
      tx_wr_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (advance) begin
        s1_vld_r <= 1'b0;
      end
      if (advance) begin
        rx_cnt_r  <= rx_cnt_nxt;
        tx_cnt_r  <= tx_cnt_nxt;
        busy_r    <= busy_nxt;
        res_r     <= res_nxt;
        abort_r   <= abort_nxt;
        stop_en_r <= stop_en_nxt;
      end
      if (tx_we) begin
        tx_wr_r[tx_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r          <= in_item;
      rx_byp_r      <= rx_we && (rx_waddr == rx_raddr);
      rx_byp_data_r <= rx_wdata;
      tx_byp_r      <= tx_we && (tx_waddr == tx_raddr);
      tx_byp_data_r <= tx_wdata;
      tx_ok_r       <= tx_wr_r[tx_raddr];
    end
  end

endmodule

// File: hdl/i2c_slave_transaction_handler_top.sv
// Top level of the I2C slave transaction handler.
// Depends on ish_pkg, ish_in_if, ish_out_if, ish_ram, ish_ctrl and ish_res_q.
//
//   channel   direction  handshake      word
//   in_chan   in         valid/ready    bus event or host request
//   out_chan  out        valid/ready    bus command, result and counters
//
// Every accepted word yields exactly one result word; a new word can be taken
// every cycle while the result queue is not full. Each word waits in the item
// register while the RAM read completes, then its result enters a two-deep queue.
// rst_n is synchronous, active low; the send buffer reads as zero after reset.
// When the result queue is full the item register holds and in_chan stalls.
module i2c_slave_transaction_handler_top #(
  parameter int RX_DEPTH = ish_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH = ish_pkg::TX_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ish_in_if.sink   in_chan,
  ish_out_if.source out_chan
);
  import ish_pkg::*;

  localparam int RX_AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  in_item_t         item;
  res_t             push_data, head;
  logic             q_full, q_push;
  logic             rx_we, rx_re, tx_we, tx_re;
  logic [RX_AW-1:0] rx_waddr, rx_raddr;
  logic [TX_AW-1:0] tx_waddr, tx_raddr;
  logic [7:0]       rx_wdata, rx_rdata, tx_wdata, tx_rdata;

  always_comb begin
    item.mode           = in_chan.mode;
    item.bus_error      = in_chan.bus_error;
    item.collision      = in_chan.collision;
    item.addr_stop_flag = in_chan.addr_stop_flag;
    item.addr_match     = in_chan.addr_match;
    item.data_flag      = in_chan.data_flag;
    item.master_reads   = in_chan.master_reads;
    item.master_nack    = in_chan.master_nack;
    item.rx_byte        = in_chan.rx_byte;
    item.host_index     = in_chan.host_index;
  end

  ish_ctrl #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH),
    .RX_AW    (RX_AW),
    .TX_AW    (TX_AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_wdata (rx_wdata),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .rx_rdata (rx_rdata),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_wdata (tx_wdata),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr),
    .tx_rdata (tx_rdata)
  );

  ish_ram #(.DEPTH(RX_DEPTH), .AW(RX_AW)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (rx_wdata),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  ish_ram #(.DEPTH(TX_DEPTH), .AW(TX_AW)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  ish_res_q u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (head)
  );

  always_comb begin
    out_chan.bus_command     = head.bus_command;
    out_chan.tx_byte         = head.tx_byte;
    out_chan.tx_valid        = head.tx_valid;
    out_chan.clear_stop_flag = head.clear_stop_flag;
    out_chan.stop_irq_enable = head.stop_irq_enable;
    out_chan.busy_res        = head.busy_res;
    out_chan.result_code     = head.result_code;
    out_chan.rx_count        = head.rx_count;
    out_chan.tx_count        = head.tx_count;
    out_chan.rx_strobe       = head.rx_strobe;
    out_chan.host_data       = head.host_data;
  end

endmodule

// File: tb/ish_response_checker.sv
// Response checker for the I2C slave transaction handler: watches both channels,
// predicts each response word and compares it field by field.
// Depends on ish_pkg, ish_in_if and ish_out_if.
module ish_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  ish_in_if           in_chan,
  ish_out_if          out_chan,
  output int unsigned fail_count,
  output int unsigned awaiting,
  output int unsigned checked_count
);
  import ish_pkg::*;

  localparam int RxDepth = RX_DEPTH_DEF;
  localparam int TxDepth = TX_DEPTH_DEF;
  localparam int RxIw    = (RxDepth > 1) ? $clog2(RxDepth) : 1;
  localparam int TxIw    = (TxDepth > 1) ? $clog2(TxDepth) : 1;

  logic [7:0]  rcv_mem [RxDepth];
  logic [7:0]  snd_mem [TxDepth];
  int unsigned rcv_cnt;
  int unsigned snd_cnt;
  logic        busy;
  logic        abort_pend;
  logic        stop_en;
  result_t     last_res;
  res_t        expected_responses [$];

  function void clear_handler_state();
    foreach (rcv_mem[i]) rcv_mem[i] = '0;
    foreach (snd_mem[i]) snd_mem[i] = '0;
    rcv_cnt    = 0;
    snd_cnt    = 0;
    busy       = 1'b0;
    abort_pend = 1'b0;
    stop_en    = 1'b0;
    last_res   = RES_UNKNOWN;
  endfunction

  function void close_transaction(input result_t code);
    last_res = code;
    busy     = 1'b0;
  endfunction

  function automatic res_t predict_response(input in_item_t w);
    res_t r;
    r = '0;
    case (w.mode)
      MODE_HOST_WR: if (w.host_index < TxDepth) snd_mem[w.host_index] = w.rx_byte;
      MODE_HOST_RD: if (w.host_index < RxDepth) r.host_data = rcv_mem[w.host_index];
      MODE_ABORT:   abort_pend = 1'b1;
      default: begin
        // Flags are taken in priority order; only the first one set counts.
        if (w.bus_error) begin
          rcv_cnt = 0;
          snd_cnt = 0;
          close_transaction(RES_BUSERR);
        end else if (w.collision) begin
          rcv_cnt = 0;
          snd_cnt = 0;
          close_transaction(RES_COLL);
        end else if (w.addr_stop_flag && w.addr_match) begin
          if (abort_pend) begin
            r.bus_command = CMD_COMPLETE;
            close_transaction(RES_ABORTED);
            abort_pend = 1'b0;
          end else begin
            busy          = 1'b1;
            last_res      = RES_UNKNOWN;
            stop_en       = 1'b0;
            rcv_cnt       = 0;
            snd_cnt       = 0;
            r.bus_command = CMD_RESPOND;
          end
        end else if (w.addr_stop_flag) begin
          stop_en           = 1'b0;
          r.clear_stop_flag = 1'b1;
          close_transaction(RES_OK);
        end else if (w.data_flag) begin
          if (w.master_reads) begin
            // A NACK only ends the transfer once at least one byte has gone out.
            if (snd_cnt != 0 && w.master_nack) begin
              r.bus_command = CMD_COMPLETE;
              close_transaction(RES_OK);
            end else if (snd_cnt < TxDepth) begin
              r.tx_byte     = snd_mem[snd_cnt[TxIw-1:0]];
              r.tx_valid    = 1'b1;
              snd_cnt++;
              r.bus_command = CMD_RESPOND;
            end else begin
              r.bus_command = CMD_COMPLETE;
              close_transaction(RES_OVERFLOW);
            end
          end else begin
            stop_en = 1'b1;
            if (rcv_cnt < RxDepth) begin
              rcv_mem[rcv_cnt[RxIw-1:0]] = w.rx_byte;
              r.rx_strobe                = 1'b1;
              rcv_cnt++;
              if (abort_pend) begin
                r.bus_command = CMD_COMPLETE;
                close_transaction(RES_ABORTED);
                abort_pend = 1'b0;
              end else begin
                r.bus_command = CMD_RESPOND;
              end
            end else begin
              r.bus_command = CMD_NACK_COMPLETE;
              close_transaction(RES_OVERFLOW);
            end
          end
        end else begin
          close_transaction(RES_FAIL);
        end
      end
    endcase
    r.stop_irq_enable = stop_en;
    r.busy_res        = busy;
    r.result_code     = last_res;
    r.rx_count        = rcv_cnt[3:0];
    r.tx_count        = snd_cnt[3:0];
    return r;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t     want;
    res_t     got;
    in_item_t word;
    if (!rst_n) begin
      clear_handler_state();
      expected_responses.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got = {out_chan.bus_command, out_chan.tx_byte, out_chan.tx_valid,
               out_chan.clear_stop_flag, out_chan.stop_irq_enable, out_chan.busy_res,
               out_chan.result_code, out_chan.rx_count, out_chan.tx_count,
               out_chan.rx_strobe, out_chan.host_data};
        if (expected_responses.size() == 0) begin
          $error("response word with no input word outstanding (bus_command %0d)",
                 got.bus_command);
          fail_count++;
        end else begin
          want = expected_responses.pop_front();
          checked_count++;
          check_field("bus_command", 8'(want.bus_command), 8'(got.bus_command));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          check_field("clear_stop_flag", 8'(want.clear_stop_flag),
                      8'(got.clear_stop_flag));
          check_field("stop_irq_enable", 8'(want.stop_irq_enable),
                      8'(got.stop_irq_enable));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("result_code", 8'(want.result_code), 8'(got.result_code));
          check_field("rx_count", 8'(want.rx_count), 8'(got.rx_count));
          check_field("tx_count", 8'(want.tx_count), 8'(got.tx_count));
          check_field("rx_strobe", 8'(want.rx_strobe), 8'(got.rx_strobe));
          check_field("host_data", want.host_data, got.host_data);
        end
      end
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
        word = {in_chan.mode, in_chan.bus_error, in_chan.collision, in_chan.addr_stop_flag,
                in_chan.addr_match, in_chan.data_flag, in_chan.master_reads,
                in_chan.master_nack, in_chan.rx_byte, in_chan.host_index};
        expected_responses.push_back(predict_response(word));
      end
    end
    awaiting <= expected_responses.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the transaction handler testbench: clock, reset, input words and
// output back-pressure, with the verdict. Depends on ish_pkg, both channel
// interfaces, the handler top and ish_response_checker.
module tb_top;
  import ish_pkg::*;

  localparam int ItemW = $bits(in_item_t);

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned awaiting;
  int unsigned checked_count;
  int unsigned hold_len;
  bit          quiet_tail;
  int unsigned words_sent;
  int unsigned words_by_mode [4];

  ish_in_if  in_chan ();
  ish_out_if out_chan ();

  i2c_slave_transaction_handler_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ish_response_checker i_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .awaiting      (awaiting),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("i2c_slave_transaction_handler_top test failed");
    $finish;
  end

  function automatic in_item_t bus_evt(input bit berr, coll, apif, amatch, dflag, mrd,
                                       mnack, input logic [7:0] b);
    in_item_t w;
    w.mode           = MODE_BUS_EVENT;
    w.bus_error      = berr;
    w.collision      = coll;
    w.addr_stop_flag = apif;
    w.addr_match     = amatch;
    w.data_flag      = dflag;
    w.master_reads   = mrd;
    w.master_nack    = mnack;
    w.rx_byte        = b;
    w.host_index     = 3'($urandom_range(0, 7));
    return w;
  endfunction

  // Host words carry random bus flags so that the decoder must ignore them.
  function automatic in_item_t host_item(input mode_t m, input logic [2:0] idx,
                                         input logic [7:0] b);
    logic [ItemW-1:0] raw;
    in_item_t         w;
    raw          = ItemW'($urandom);
    w            = raw;
    w.mode       = m;
    w.host_index = idx;
    w.rx_byte    = b;
    return w;
  endfunction

  task automatic put_fields(input in_item_t w);
    {in_chan.mode, in_chan.bus_error, in_chan.collision, in_chan.addr_stop_flag,
     in_chan.addr_match, in_chan.data_flag, in_chan.master_reads, in_chan.master_nack,
     in_chan.rx_byte, in_chan.host_index} <= w;
  endtask

  task automatic offer_word(input in_item_t w);
    logic [ItemW-1:0] junk;
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      junk = ItemW'($urandom);
      in_chan.valid <= 1'b0;
      put_fields(junk);
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    put_fields(w);
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    words_by_mode[w.mode]++;
    words_sent++;
  endtask

  task automatic settle_outputs();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  // Mostly well-formed transfers with random content, plus host traffic and noise.
  task automatic random_burst();
    logic [ItemW-1:0] raw;
    int unsigned      pick;
    int unsigned      n;
    int unsigned      k;
    bit               reading;
    bit               b;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      raw = ItemW'($urandom);
      offer_word(raw);
    end else if (pick < 30) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        k = $urandom_range(0, 7);
        if (k == 0) offer_word(host_item(MODE_ABORT, 3'($urandom), 8'($urandom)));
        else if (k < 4) offer_word(host_item(MODE_HOST_RD, 3'($urandom), 8'($urandom)));
        else offer_word(host_item(MODE_HOST_WR, 3'($urandom), 8'($urandom)));
      end
    end else begin
      reading = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0)
        offer_word(host_item(MODE_ABORT, 3'($urandom), 8'($urandom)));
      offer_word(bus_evt(0, 0, 1, 1, 1'($urandom), 1'($urandom), 1'($urandom),
                         8'($urandom)));
      n = $urandom_range(0, 10);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          b = 1'($urandom_range(0, 1));
          offer_word(bus_evt(b, !b, 1'($urandom), 1'($urandom), 1'($urandom),
                             1'($urandom), 1'($urandom), 8'($urandom)));
        end else begin
          offer_word(bus_evt(0, 0, 0, 1'($urandom), 1, reading,
                             reading && $urandom_range(0, 5) == 0, 8'($urandom)));
        end
      end
      if ($urandom_range(0, 9) != 0)
        offer_word(bus_evt(0, 0, 1, 0, 1'($urandom), 1'($urandom), 1'($urandom),
                           8'($urandom)));
    end
  endtask

  // Output back-pressure. A long hold-off can be requested through hold_len.
  initial begin
    int unsigned n;
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_len != 0) begin
        n        = hold_len;
        hold_len = 0;
        out_chan.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat (quiet_tail ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned i;
    bit          hold_done;
    bit          pause_done;
    hold_len   = 0;
    quiet_tail = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    words_sent = 0;
    foreach (words_by_mode[m]) words_by_mode[m] = 0;
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    put_fields('0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: extremes, flag priority, overflow, abort and NACK ends.
    offer_word(host_item(MODE_HOST_WR, 3'd0, 8'hFF));
    offer_word(host_item(MODE_HOST_WR, 3'd7, 8'h00));
    offer_word(bus_evt(0, 0, 0, 0, 0, 0, 0, 8'($urandom)));
    offer_word(bus_evt(0, 0, 1, 0, 1, 1, 1, 8'($urandom)));
    offer_word(bus_evt(1, 1, 1, 1, 1, 0, 0, 8'($urandom)));
    offer_word(bus_evt(0, 1, 1, 1, 1, 0, 0, 8'($urandom)));
    offer_word(bus_evt(0, 0, 1, 1, 1, 1, 0, 8'($urandom)));
    // Nine writes: the first eight fill every receive entry, the ninth overflows.
    for (i = 0; i < 9; i++)
      offer_word(bus_evt(0, 0, 0, 0, 1, 0, 1,
                         (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom)));
    offer_word(host_item(MODE_HOST_RD, 3'd0, 8'($urandom)));
    offer_word(host_item(MODE_HOST_RD, 3'd7, 8'($urandom)));
    offer_word(host_item(MODE_ABORT, 3'($urandom), 8'($urandom)));
    offer_word(bus_evt(0, 0, 1, 1, 0, 0, 0, 8'($urandom)));
    offer_word(bus_evt(0, 0, 1, 1, 0, 0, 0, 8'($urandom)));
    // A NACK on the first read word is ignored; the second one ends the transfer.
    offer_word(bus_evt(0, 0, 0, 0, 1, 1, 1, 8'($urandom)));
    offer_word(bus_evt(0, 0, 0, 0, 1, 1, 1, 8'($urandom)));
    offer_word(host_item(MODE_ABORT, 3'($urandom), 8'($urandom)));
    offer_word(bus_evt(0, 0, 0, 0, 1, 0, 0, 8'hA5));
    offer_word(bus_evt(0, 0, 1, 0, 0, 0, 0, 8'($urandom)));
    settle_outputs();

    while (words_sent < 900) begin
      if (!hold_done && words_sent >= 300) begin
        hold_len  = 40;
        hold_done = 1'b1;
      end
      if (!pause_done && words_sent >= 600) begin
        settle_outputs();
        pause_done = 1'b1;
      end
      if (words_sent >= 800) quiet_tail = 1'b1;
      random_burst();
    end

    in_chan.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (8) @(posedge clk);

    $display("Covered %0d words: %0d bus events, %0d send writes, %0d receive reads, %0d aborts.",
             words_sent, words_by_mode[MODE_BUS_EVENT], words_by_mode[MODE_HOST_WR],
             words_by_mode[MODE_HOST_RD], words_by_mode[MODE_ABORT]);
    $display("%0d responses checked, including a long output stall and a full drain.",
             checked_count);
    if (fail_count == 0 && awaiting == 0) begin
      $display("i2c_slave_transaction_handler_top test passed");
    end else begin
      $display("i2c_slave_transaction_handler_top test failed");
    end
    $finish;
  end

endmodule
